[rtl/rliw_pkg.sv]
// Shared types and constants of the row linear interpolation warp unit.
package rliw_pkg;

    localparam int COL_W       = 7;
    localparam int SAMPLE_W    = 8;
    localparam int OFFSET_W    = 16;
    localparam int ROW_WIDTH_W = 8;
    localparam int FRAC_W      = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    // Neighbor index width: column minus a full 16-bit shift, plus sign.
    localparam int IDX_W = OFFSET_W + 2;

    // Fixed-point unit weight before it is shifted into place.
    localparam logic [OFFSET_W-1:0] WEIGHT_ONE = 16'h0001;

    // Register reset values.
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 8'd128;
    localparam logic [FRAC_W-1:0]      FRAC_BITS_RST = 4'd8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAC_BITS = 1'b1;

    // Item operation codes.
    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_COMPUTE = 1'b1
    } rliw_op_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL,
        ST_SUM
    } rliw_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_en;
        logic cap_en;
        logic fetch_en;
        logic mul_en;
        logic out_load;
    } rliw_cmd_t;

endpackage

[rtl/rliw_if.sv]
// Handshake channel interfaces of the row linear interpolation warp unit.
interface rliw_in_if;
    logic                              valid;
    logic                              ready;
    logic                              operation;
    logic [rliw_pkg::COL_W-1:0]        column;
    logic signed [rliw_pkg::SAMPLE_W-1:0] sample;
    logic signed [rliw_pkg::OFFSET_W-1:0] offset;

    modport source (output valid, operation, column, sample, offset, input ready);
    modport sink   (input valid, operation, column, sample, offset, output ready);
endinterface

interface rliw_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [rliw_pkg::COL_W-1:0]           out_column;
    logic signed [rliw_pkg::SAMPLE_W-1:0] out_value;

    modport source (output valid, out_column, out_value, input ready);
    modport sink   (input valid, out_column, out_value, output ready);
endinterface

interface rliw_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [rliw_pkg::CFG_INDEX_W-1:0]  index;
    logic [rliw_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/rliw_ctrl.sv]
// Controller state machine of the row linear interpolation warp unit.
module rliw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_operation,
    output logic                in_ready,
    input  logic                out_ready,
    output logic                out_valid,
    output rliw_pkg::rliw_cmd_t cmd
);

    rliw_pkg::rliw_state_t state_reg;
    rliw_pkg::rliw_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  is_compute;

    assign is_compute = (in_operation == rliw_pkg::OP_COMPUTE);

    // State and output-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rliw_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rliw_pkg::ST_IDLE:
            begin
                if (in_valid && is_compute)
                    state_next = rliw_pkg::ST_FETCH;
            end
            rliw_pkg::ST_FETCH: state_next = rliw_pkg::ST_MUL;
            rliw_pkg::ST_MUL:   state_next = rliw_pkg::ST_SUM;
            rliw_pkg::ST_SUM:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = rliw_pkg::ST_IDLE;
            end
            default: state_next = rliw_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            rliw_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.wr_en  = in_valid && !is_compute;
                cmd.cap_en = in_valid && is_compute;
            end
            rliw_pkg::ST_FETCH: cmd.fetch_en = 1'b1;
            rliw_pkg::ST_MUL:   cmd.mul_en   = 1'b1;
            rliw_pkg::ST_SUM:   cmd.out_load = !out_valid_reg || out_ready;
            default:            in_ready     = 1'b0;
        endcase
    end

    // The output register fills on a finished compute and drains when taken.
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

[rtl/rliw_datapath.sv]
// Datapath of the row linear interpolation warp unit: row store, weights, blend.
module rliw_datapath #(
    parameter int MAX_WIDTH = 128
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rliw_pkg::rliw_cmd_t                   cmd,
    input  logic [rliw_pkg::COL_W-1:0]            column,
    input  logic signed [rliw_pkg::SAMPLE_W-1:0]  sample,
    input  logic signed [rliw_pkg::OFFSET_W-1:0]  offset,
    input  logic                                  cfg_we,
    input  logic [rliw_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [rliw_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic [rliw_pkg::COL_W-1:0]            out_column,
    output logic signed [rliw_pkg::SAMPLE_W-1:0]  out_value
);

    localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int OW    = rliw_pkg::OFFSET_W;
    localparam int SW    = rliw_pkg::SAMPLE_W;
    localparam int IW    = rliw_pkg::IDX_W;
    localparam int LIM_W = IW - 1;
    localparam logic [LIM_W-1:0] MaxLim = LIM_W'(MAX_WIDTH);

    // Configuration registers.
    logic [rliw_pkg::ROW_WIDTH_W-1:0] row_width_reg;
    logic [rliw_pkg::FRAC_W-1:0]      frac_bits_reg;

    // Row store.
    logic [SW-1:0] mem [MAX_WIDTH];

    // Pipeline payload registers.
    logic [rliw_pkg::COL_W-1:0] col_reg;
    logic signed [OW-1:0]       offset_reg;
    logic [SW-1:0]              rd_l_reg;
    logic [SW-1:0]              rd_r_reg;
    logic                       ok_l_reg;
    logic                       ok_r_reg;
    logic [OW-1:0]              wl_reg;
    logic [OW-1:0]              wr_reg;
    logic [OW-1:0]              prod_l_reg;
    logic [OW-1:0]              prod_r_reg;
    logic [rliw_pkg::COL_W-1:0] out_column_reg;
    logic [SW-1:0]              out_value_reg;

    // Combinational values.
    logic              load_in_range;
    logic [AW-1:0]     wr_addr;
    logic signed [OW-1:0] shift;
    logic [IW-1:0]     idx_r;
    logic [IW-1:0]     idx_l;
    logic [LIM_W-1:0]  row_lim;
    logic [LIM_W-1:0]  lim;
    logic [OW-1:0]     unit_w;
    logic [OW-1:0]     wl_next;
    logic [OW-1:0]     wr_next;
    logic              ok_l_next;
    logic              ok_r_next;
    logic [OW-1:0]     lv;
    logic [OW-1:0]     rv;
    logic [2*OW-1:0]   full_l;
    logic [2*OW-1:0]   full_r;
    logic [OW-1:0]     sum;
    logic signed [OW-1:0] res;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= rliw_pkg::ROW_WIDTH_RST;
            frac_bits_reg <= rliw_pkg::FRAC_BITS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rliw_pkg::REG_ROW_WIDTH: row_width_reg <= cfg_data;
                rliw_pkg::REG_FRAC_BITS: frac_bits_reg <= cfg_data[rliw_pkg::FRAC_W-1:0];
                default:                 row_width_reg <= row_width_reg;
            endcase
        end
    end

    // Loads past the end of the store are dropped.
    assign load_in_range = (32'(column) < MAX_WIDTH);
    assign wr_addr       = AW'(column);

    // Integer shift and fractional weights of the offset.
    assign shift   = offset_reg >>> frac_bits_reg;
    assign unit_w  = rliw_pkg::WEIGHT_ONE << frac_bits_reg;
    assign wl_next = offset_reg & (unit_w - rliw_pkg::WEIGHT_ONE);
    assign wr_next = unit_w - wl_next;

    // Neighbor indexes: right is column minus shift, left one below it.
    assign idx_r = IW'(col_reg) - {{(IW-OW){shift[OW-1]}}, shift};
    assign idx_l = idx_r - IW'(1);

    // Effective row limit is the smaller of row width and store depth.
    assign row_lim = LIM_W'(row_width_reg);
    assign lim     = (row_lim < MaxLim) ? row_lim : MaxLim;

    assign ok_r_next = !idx_r[IW-1] && (idx_r[LIM_W-1:0] < lim);
    assign ok_l_next = !idx_l[IW-1] && (idx_l[LIM_W-1:0] < lim);

    // Row store write port and two registered read ports.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && load_in_range)
            mem[wr_addr] <= sample;
        if (cmd.fetch_en)
        begin
            rd_l_reg <= mem[idx_l[AW-1:0]];
            rd_r_reg <= mem[idx_r[AW-1:0]];
        end
    end

    // Neighbors outside the row read as zero; samples are sign-extended.
    assign lv = ok_l_reg ? {{(OW-SW){rd_l_reg[SW-1]}}, rd_l_reg} : '0;
    assign rv = ok_r_reg ? {{(OW-SW){rd_r_reg[SW-1]}}, rd_r_reg} : '0;

    assign full_l = lv * wl_reg;
    assign full_r = rv * wr_reg;

    // Blend wraps at 16 bits, then shifts back and truncates to a sample.
    assign sum = prod_l_reg + prod_r_reg;
    assign res = $signed(sum) >>> frac_bits_reg;

    // Payload pipeline registers.
    always_ff @(posedge clk)
    begin
        if (cmd.cap_en)
        begin
            col_reg    <= column;
            offset_reg <= offset;
        end
        if (cmd.fetch_en)
        begin
            wl_reg   <= wl_next;
            wr_reg   <= wr_next;
            ok_l_reg <= ok_l_next;
            ok_r_reg <= ok_r_next;
        end
        if (cmd.mul_en)
        begin
            prod_l_reg <= full_l[OW-1:0];
            prod_r_reg <= full_r[OW-1:0];
        end
        if (cmd.out_load)
        begin
            out_column_reg <= col_reg;
            out_value_reg  <= res[SW-1:0];
        end
    end

    assign out_column = out_column_reg;
    assign out_value  = out_value_reg;

endmodule

[rtl/row_linear_interp_warp_unit.sv]
// Top level of the row linear interpolation warp unit.
// Warps one row of int8 samples horizontally: load items write a sample into a
// MAX_WIDTH-entry row store, and compute items blend the two neighbors of
// (column - shift) with fractional weights taken from the item's fixed-point
// offset, giving one result per compute. A load item is taken every cycle
// while the block is idle. A compute item steps through accept, store read with
// weight setup, multiply, and blend into the output register before the next
// item is accepted; the store's registered reads and the single multiply stage
// set these steps. A finished result waits in the output register while the
// next item is accepted, and a compute stalls in its blend step only while the
// previous result is still untaken. Configuration writes are always taken.
module row_linear_interp_warp_unit #(
    parameter int MAX_WIDTH = 128
) (
    input  logic      clk,
    input  logic      rst_n,
    rliw_in_if.sink   pixel,
    rliw_out_if.source result,
    rliw_cfg_if.sink  cfg
);

    rliw_pkg::rliw_cmd_t cmd;

    assign cfg.ready = 1'b1;

    // Controller.
    rliw_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (pixel.valid),
        .in_operation (pixel.operation),
        .in_ready     (pixel.ready),
        .out_ready    (result.ready),
        .out_valid    (result.valid),
        .cmd          (cmd)
    );

    // Datapath.
    rliw_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .column     (pixel.column),
        .sample     (pixel.sample),
        .offset     (pixel.offset),
        .cfg_we     (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .out_column (result.out_column),
        .out_value  (result.out_value)
    );

endmodule
